// ===== src/tvfs_pkg.sv =====
`default_nettype none
package tvfs_pkg;

   localparam int POS_W   = 24;
   localparam int DIFF_W  = 25;
   localparam int SCALE_W = 32;
   localparam int PROD_W  = 58;
   localparam int VEC_W   = 16;
   localparam int CELL_W  = 4;
   localparam int FRAC_W  = 8;
   localparam int WGT_W   = 9;
   localparam int WXY_W   = 17;
   localparam int W_W     = 25;
   localparam int ACC_W   = 42;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z  = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_LOC,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== src/tvfs_ram.sv =====
`default_nettype none
module tvfs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== src/trilinear_vector_field_sampler_core.sv =====
`default_nettype none
// Sequence: a write transaction is stored at the edge that accepts it; a sample result becomes valid
//   once the three axes are located one at a time on one shared multiplier, the eight corners are read
//   from the single grid memory port, the blend pipeline drains and the output register is loaded.
// Throughput: one sample at a time, no request is taken until its result is loaded, which waits while an earlier
//   result waits to be taken; one write per cycle while idle.
// Reset: synchronous, active high; clears control and origin, sets scale to one; grid undefined until written.
module trilinear_vector_field_sampler_core
   import tvfs_pkg::*;
#(
   parameter int GRID_X = 16,
   parameter int GRID_Y = 16,
   parameter int GRID_Z = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_command,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [POS_W-1:0]  req_pos_z,
   input  wire logic [CELL_W-1:0]        req_cell_x,
   input  wire logic [CELL_W-1:0]        req_cell_y,
   input  wire logic [CELL_W-1:0]        req_cell_z,
   input  wire logic signed [VEC_W-1:0]  req_vec_x,
   input  wire logic signed [VEC_W-1:0]  req_vec_y,
   input  wire logic signed [VEC_W-1:0]  req_vec_z,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [VEC_W-1:0]       rsp_flow_x,
   output logic signed [VEC_W-1:0]       rsp_flow_y,
   output logic signed [VEC_W-1:0]       rsp_flow_z,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int GMAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GMAX    = (GMAX_XY > GRID_Z) ? GMAX_XY : GRID_Z;
   localparam int CW      = $clog2(GMAX);
   localparam int MEM_W   = 3 * VEC_W;

   // Configuration registers
   logic signed [POS_W-1:0]  origin_ff [3];
   logic [SCALE_W-1:0]       scale_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            origin_ff[i] <= '0;
            scale_ff[i]  <= SCALE_ONE;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_ff[0] <= csr_wdata[POS_W-1:0];
            CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata[POS_W-1:0];
            CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata[POS_W-1:0];
            CSR_SCALE_X:  scale_ff[0]  <= csr_wdata;
            CSR_SCALE_Y:  scale_ff[1]  <= csr_wdata;
            CSR_SCALE_Z:  scale_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control state
   state_type state_ff, state_in;
   logic [1:0] ax_ff;
   logic [2:0] k_ff;
   logic       v1_ff, v2_ff;
   logic       rsp_valid_ff;

   logic req_fire, sample_fire, write_fire, done_fire;
   logic loc_last, read_last, drain_empty;

   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && (req_command == CMD_SAMPLE);
   assign write_fire  = req_fire && (req_command == CMD_WRITE);
   assign loc_last    = (ax_ff == 2'd2);
   assign read_last   = (k_ff == 3'd7);
   assign drain_empty = !v1_ff && !v2_ff;
   assign done_fire   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (sample_fire) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_LOC;
         ST_LOC:   state_in = loc_last ? ST_READ : ST_DIFF;
         ST_READ:  if (read_last) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_empty) state_in = ST_DONE;
         ST_DONE:  if (done_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   logic issue_rd;
   always_comb begin
      req_ready = 1'b0;
      issue_rd  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_READ: issue_rd  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= '0;
         k_ff         <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (sample_fire) begin
            ax_ff <= '0;
            k_ff  <= '0;
         end
         if (state_ff == ST_LOC && !loc_last) ax_ff <= ax_ff + 2'd1;
         if (issue_rd) k_ff <= k_ff + 3'd1;
         v1_ff <= issue_rd;
         v2_ff <= v1_ff;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Locate: subtract origin, multiply by scale, clamp and split, one axis at a time
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [DIFF_W-1:0] d_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [CW-1:0]            c0_ff [3];
   logic [CW-1:0]            c1_ff [3];
   logic [FRAC_W-1:0]        f_ff  [3];

   logic signed [DIFF_W-1:0] d_in;
   logic signed [PROD_W-1:0] prod_in;
   logic [PROD_W-33:0]       cell_raw;
   logic [PROD_W-33:0]       size_m1;
   logic [CW-1:0]            c0_in, c1_in;
   logic [FRAC_W-1:0]        f_in;

   assign d_in = DIFF_W'(pos_ff[ax_ff]) - DIFF_W'(origin_ff[ax_ff]);
   assign prod_in = d_ff * $signed({1'b0, scale_ff[ax_ff]});
   assign cell_raw = prod_ff[PROD_W-1:32];

   always_comb begin
      case (ax_ff)
         2'd0:    size_m1 = (PROD_W-32)'(GRID_X - 1);
         2'd1:    size_m1 = (PROD_W-32)'(GRID_Y - 1);
         default: size_m1 = (PROD_W-32)'(GRID_Z - 1);
      endcase
      if (prod_ff[PROD_W-1]) begin
         // below the minimum: clamp to the low edge
         c0_in = '0;
         f_in  = '0;
      end else if (cell_raw >= size_m1) begin
         c0_in = size_m1[CW-1:0];
         f_in  = '0;
      end else begin
         c0_in = cell_raw[CW-1:0];
         f_in  = prod_ff[31:24];
      end
      c1_in = (c0_in == size_m1[CW-1:0]) ? c0_in : c0_in + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (sample_fire) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      if (state_ff == ST_DIFF) d_ff <= d_in;
      if (state_ff == ST_MUL)  prod_ff <= prod_in;
      if (state_ff == ST_LOC) begin
         c0_ff[ax_ff] <= c0_in;
         c1_ff[ax_ff] <= c1_in;
         f_ff[ax_ff]  <= f_in;
      end
   end

   // Grid memory: writes from write transactions, reads for the eight corners
   logic [ADDR_W-1:0] waddr, raddr;
   logic              mem_we;
   logic [MEM_W-1:0]  rdata;
   logic [CW-1:0]     cx, cy, cz;

   assign mem_we = write_fire
      && (int'(req_cell_x) < GRID_X)
      && (int'(req_cell_y) < GRID_Y)
      && (int'(req_cell_z) < GRID_Z);

   assign waddr = ADDR_W'(req_cell_x)
      + ADDR_W'(req_cell_y) * ADDR_W'(GRID_X)
      + ADDR_W'(req_cell_z) * ADDR_W'(GRID_X * GRID_Y);

   assign cx = k_ff[0] ? c1_ff[0] : c0_ff[0];
   assign cy = k_ff[1] ? c1_ff[1] : c0_ff[1];
   assign cz = k_ff[2] ? c1_ff[2] : c0_ff[2];
   assign raddr = ADDR_W'(cx)
      + ADDR_W'(cy) * ADDR_W'(GRID_X)
      + ADDR_W'(cz) * ADDR_W'(GRID_X * GRID_Y);

   tvfs_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (mem_we),
      .waddr (waddr),
      .wdata ({req_vec_z, req_vec_y, req_vec_x}),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Blend pipeline: weight xy with the read, then full weight, then accumulate
   logic [WGT_W-1:0]  wx, wy, wz;
   logic [WXY_W-1:0]  wxy_ff;
   logic [WGT_W-1:0]  wz1_ff;
   logic [W_W-1:0]    w_ff;
   logic [MEM_W-1:0]  corner_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic [2*WGT_W-1:0]      wxy_full;
   logic [WXY_W+WGT_W-1:0]  w_full;

   assign wx = k_ff[0] ? {1'b0, f_ff[0]} : 9'd256 - {1'b0, f_ff[0]};
   assign wy = k_ff[1] ? {1'b0, f_ff[1]} : 9'd256 - {1'b0, f_ff[1]};
   assign wz = k_ff[2] ? {1'b0, f_ff[2]} : 9'd256 - {1'b0, f_ff[2]};
   assign wxy_full = wx * wy;
   assign w_full   = wxy_ff * wz1_ff;

   always_ff @(posedge clock) begin
      if (issue_rd) begin
         wxy_ff <= wxy_full[WXY_W-1:0];
         wz1_ff <= wz;
      end
      if (v1_ff) begin
         w_ff      <= w_full[W_W-1:0];
         corner_ff <= rdata;
      end
      for (int c = 0; c < 3; c++) begin
         if (sample_fire) begin
            acc_ff[c] <= '0;
         end else if (v2_ff) begin
            acc_ff[c] <= acc_ff[c]
               + $signed(corner_ff[c*VEC_W +: VEC_W]) * $signed({1'b0, w_ff});
         end
      end
   end

   // Round half up and drop the 24 fraction bits; hold until taken
   logic signed [ACC_W-1:0] rnd [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rnd[c] = (acc_ff[c] + ACC_W'(1 << 23)) >>> 24;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_flow_x <= rnd[0][VEC_W-1:0];
         rsp_flow_y <= rnd[1][VEC_W-1:0];
         rsp_flow_z <= rnd[2][VEC_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // result leaves only through a completed transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_ready))
      else $error("result dropped without a transaction");

   // the blend pipeline must be empty before the result is formed
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!v1_ff && !v2_ff))
      else $error("result formed with corners in flight");

   // no new transaction while a sample is in progress
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken while busy");

   // corner pipeline follows its read issue
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("blend pipeline out of step");
`endif

endmodule
`default_nettype wire
